>>> rtl/core/assert_macros.svh
// Assertion macros used by the checker file of the supervisor.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion clocked on aclk and switched off while reset is applied.
`define BCDS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Concurrent assertion that a condition is never seen outside reset.
`define BCDS_ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(expr)) \
        else $error(msg);

`endif

>>> rtl/core/bcds_pkg.sv
// Types and constants of the battery charge and drive supervisor.
`timescale 1ns / 1ps

package bcds_pkg;

    // Operation codes of an input transfer.
    localparam logic [1:0] OP_CHARGE  = 2'd0;
    localparam logic [1:0] OP_FORWARD = 2'd1;
    localparam logic [1:0] OP_LEFT    = 2'd2;
    localparam logic [1:0] OP_RIGHT   = 2'd3;

    // Status codes of a result transfer.
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_OPEN  = 2'd1;
    localparam logic [1:0] STATUS_CRIT  = 2'd2;
    localparam logic [1:0] STATUS_LIMIT = 2'd3;

    // Thermal fault levels.
    localparam logic [1:0] LVL_NONE = 2'd0;
    localparam logic [1:0] LVL_LOW  = 2'd1;
    localparam logic [1:0] LVL_HIGH = 2'd2;
    localparam logic [1:0] LVL_CRIT = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_STEP_SECONDS    = 2'd0;
    localparam logic [1:0] CFG_CAPACITY_AH     = 2'd1;
    localparam logic [1:0] CFG_STEERING_EFFORT = 2'd2;

    // Pump duties.
    localparam logic [6:0] PUMP_OFF  = 7'd0;
    localparam logic [6:0] PUMP_HALF = 7'd50;
    localparam logic [6:0] PUMP_FULL = 7'd100;

    // Temperature thresholds in degrees Celsius.
    localparam logic signed [7:0] TEMP_CRIT  = 8'sd55;
    localparam logic signed [7:0] TEMP_HIGH  = 8'sd45;
    localparam logic signed [7:0] TEMP_LOW   = 8'sd35;
    localparam logic signed [7:0] TEMP_CLEAR = 8'sd28;

    // SOC limits in 1/65536 percent.
    localparam logic [22:0] SOC_FULL = 23'd6553600;
    localparam logic [22:0] SOC_LOW  = 23'd6553;

    // Current limit in amperes.
    localparam logic signed [10:0] CUR_MAX = 11'sd1023;
    localparam logic signed [10:0] CUR_MIN = -11'sd1023;

    // Power in kW to watts.
    localparam logic [9:0] POWER_SCALE = 10'd1000;

    // Coulomb scaling: dt*819200/(441*cap), with 819200 = 25 << 15.
    localparam logic [8:0] DEN_FACTOR = 9'd441;
    localparam logic [4:0] CHG_MULT   = 5'd25;
    localparam int         SOC_SHIFT  = 15;

    // Shared serial divider geometry.
    localparam int         DIV_QW    = 23;
    localparam int         DIV_RW    = 19;
    localparam int         CNT_W     = 5;
    localparam logic [4:0] PWR_ITERS = 5'd20;
    localparam logic [4:0] SOC_ITERS = 5'd23;

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIVP,
        ST_CUR,
        ST_MUL,
        ST_NUM,
        ST_DLOAD,
        ST_DIVS,
        ST_DONE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic prep;
        logic div_pwr;
        logic cur;
        logic mul;
        logic num;
        logic div_soc;
        logic commit;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic drive_div;
        logic div_busy;
    } sts_t;

endpackage

>>> rtl/core/bcds_div.sv
// Restoring serial divider, one quotient bit per clock, shared by both divisions.
`timescale 1ns / 1ps

module bcds_div
    import bcds_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [CNT_W-1:0]  iters,
    input  logic [DIV_RW-1:0] rem_init,
    input  logic [DIV_QW-1:0] shf_init,
    input  logic [DIV_RW-1:0] divisor,
    output logic              busy,
    output logic [DIV_QW-1:0] quotient
);

    logic              busy_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [DIV_RW-1:0] rem_reg;
    logic [DIV_QW-1:0] shf_reg;
    logic [DIV_RW-1:0] dsr_reg;
    logic [DIV_RW:0]   trial;
    logic [DIV_RW:0]   diff;
    logic              ge;

    // Trial subtraction of the divisor from the partial remainder.
    assign trial = {rem_reg, shf_reg[DIV_QW-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign ge    = (trial >= {1'b0, dsr_reg});

    // Iteration count and busy flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= iters;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Remainder and numerator/quotient shift register.
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= rem_init;
            shf_reg <= shf_init;
            dsr_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= ge ? diff[DIV_RW-1:0] : trial[DIV_RW-1:0];
            shf_reg <= {shf_reg[DIV_QW-2:0], ge};
        end
    end

    assign busy     = busy_reg;
    assign quotient = shf_reg;

endmodule

>>> rtl/core/bcds_ctrl.sv
// Controller state machine that sequences one supervision step.
`timescale 1ns / 1ps

module bcds_ctrl
    import bcds_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    output logic m_valid,
    input  logic m_ready,
    output cmd_t cmd,
    input  sts_t sts
);

    state_t state_reg;
    state_t state_next;
    logic   mvalid_reg;
    logic   mvalid_next;
    logic   out_free;

    // The output register can take a result when empty or being emptied.
    assign out_free = !mvalid_reg || m_ready;

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                state_next = sts.drive_div ? ST_DIVP : ST_CUR;
            end
            ST_DIVP: begin
                if (!sts.div_busy) begin
                    state_next = ST_CUR;
                end
            end
            ST_CUR:   state_next = ST_MUL;
            ST_MUL:   state_next = ST_NUM;
            ST_NUM:   state_next = ST_DLOAD;
            ST_DLOAD: state_next = ST_DIVS;
            ST_DIVS: begin
                if (!sts.div_busy) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Command outputs.
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            ST_PREP: begin
                cmd.prep    = 1'b1;
                cmd.div_pwr = sts.drive_div;
            end
            ST_DIVP:  cmd = '0;
            ST_CUR:   cmd.cur = 1'b1;
            ST_MUL:   cmd.mul = 1'b1;
            ST_NUM:   cmd.num = 1'b1;
            ST_DLOAD: cmd.div_soc = 1'b1;
            ST_DIVS:  cmd = '0;
            ST_DONE:  cmd.commit = out_free;
            default:  cmd = '0;
        endcase
    end

    // Result valid flag.
    always_comb begin
        if (cmd.commit) begin
            mvalid_next = 1'b1;
        end else if (m_ready) begin
            mvalid_next = 1'b0;
        end else begin
            mvalid_next = mvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
        end
    end

    assign m_valid = mvalid_reg;

endmodule

>>> rtl/core/bcds_dpath.sv
// Datapath: configuration, current and SOC arithmetic, thermal state and result register.
`timescale 1ns / 1ps

module bcds_dpath
    import bcds_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  cmd_t               cmd,
    output sts_t               sts,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_index,
    input  logic [11:0]        cfg_wdata,
    input  logic [1:0]         s_operation,
    input  logic [9:0]         s_target,
    input  logic [9:0]         s_pack_voltage,
    input  logic signed [10:0] s_pack_current,
    input  logic               s_contactor_open,
    input  logic signed [7:0]  s_cell_temperature,
    input  logic [22:0]        s_stored_soc,
    output logic [1:0]         m_status,
    output logic [22:0]        m_soc_estimate,
    output logic signed [10:0] m_command_current,
    output logic               m_cool_request,
    output logic [6:0]         m_pump_duty,
    output logic [1:0]         m_thermal_level
);

    // Configuration registers.
    logic [11:0] step_reg;
    logic [9:0]  cap_reg;
    logic [9:0]  steer_reg;

    // Captured input transfer.
    logic [1:0]         op_reg;
    logic [9:0]         tgt_reg;
    logic [9:0]         volt_reg;
    logic signed [10:0] pc_reg;
    logic               open_reg;
    logic signed [7:0]  temp_reg;
    logic [22:0]        stored_reg;

    // Intermediate values.
    logic signed [10:0] meas_reg;
    logic               pneg_reg;
    logic [18:0]        den_reg;
    logic signed [10:0] cur_reg;
    logic [21:0]        prod_reg;
    logic [41:0]        num_reg;
    logic               sat_reg;

    // Supervisor state kept between steps.
    logic [22:0] soc_reg;
    logic        seeded_reg;
    logic [1:0]  fault_reg;
    logic [6:0]  pump_reg;

    // Result register.
    logic [1:0]         status_out_reg;
    logic [22:0]        soc_out_reg;
    logic signed [10:0] cur_out_reg;
    logic               cool_out_reg;

    // Combinational signals.
    logic               turn;
    logic signed [10:0] pc_clamp;
    logic signed [10:0] power;
    logic signed [10:0] power_neg;
    logic [9:0]         pabs;
    logic [19:0]        pnum;
    logic [9:0]         cap_eff;
    logic [18:0]        den_val;
    logic               div_start;
    logic [CNT_W-1:0]   div_iters;
    logic [DIV_RW-1:0]  div_rem;
    logic [DIV_QW-1:0]  div_shf;
    logic [DIV_RW-1:0]  div_dsr;
    logic               div_busy;
    logic [DIV_QW-1:0]  quotient;
    logic signed [20:0] req;
    logic signed [20:0] meas_x;
    logic signed [20:0] mn;
    logic signed [21:0] neg;
    logic signed [10:0] drive_cur;
    logic signed [10:0] cur_val;
    logic signed [10:0] cur_neg;
    logic [9:0]         cabs;
    logic [26:0]        scaled;
    logic [22:0]        base;
    logic [23:0]        sum;
    logic [22:0]        diff;
    logic [22:0]        soc_new;
    logic [1:0]         fault_new;
    logic [6:0]         pump_new;
    logic [1:0]         status_new;
    logic               cool_new;

    // Configuration writes; an index beyond the list is ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg  <= 12'd1;
            cap_reg   <= 10'd100;
            steer_reg <= 10'd0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_STEP_SECONDS:    step_reg  <= cfg_wdata;
                CFG_CAPACITY_AH:     cap_reg   <= cfg_wdata[9:0];
                CFG_STEERING_EFFORT: steer_reg <= cfg_wdata[9:0];
                default:             step_reg  <= step_reg;
            endcase
        end
    end

    // Input capture on an accepted transfer.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg     <= s_operation;
            tgt_reg    <= s_target;
            volt_reg   <= s_pack_voltage;
            pc_reg     <= s_pack_current;
            open_reg   <= s_contactor_open;
            temp_reg   <= s_cell_temperature;
            stored_reg <= s_stored_soc;
        end
    end

    // Measured current limited to the symmetric range, and requested power.
    assign turn      = (op_reg == OP_LEFT) || (op_reg == OP_RIGHT);
    assign pc_clamp  = (pc_reg < CUR_MIN) ? CUR_MIN : pc_reg;
    assign power     = $signed({1'b0, tgt_reg}) -
                       (turn ? $signed({1'b0, steer_reg}) : 11'sd0);
    assign power_neg = -power;
    assign pabs      = power[10] ? power_neg[9:0] : power[9:0];
    assign pnum      = 20'(pabs) * 20'(POWER_SCALE);
    assign cap_eff   = (cap_reg == 10'd0) ? 10'd1 : cap_reg;
    assign den_val   = 19'(cap_eff) * 19'(DEN_FACTOR);

    assign sts.drive_div = (op_reg != OP_CHARGE) && (volt_reg != 10'd0);
    assign sts.div_busy  = div_busy;

    always_ff @(posedge aclk) begin
        if (cmd.prep) begin
            meas_reg <= pc_clamp;
            pneg_reg <= power[10];
            den_reg  <= den_val;
        end
    end

    // Divider operands: power over voltage, or coulomb numerator over scaled capacity.
    assign div_start = cmd.div_pwr || cmd.div_soc;
    assign div_iters = cmd.div_soc ? SOC_ITERS : PWR_ITERS;
    assign div_rem   = cmd.div_soc ? num_reg[41:DIV_QW] : '0;
    assign div_shf   = cmd.div_soc ? num_reg[DIV_QW-1:0] : {pnum, 3'b000};
    assign div_dsr   = cmd.div_soc ? den_reg : 19'(volt_reg);

    bcds_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .iters    (div_iters),
        .rem_init (div_rem),
        .shf_init (div_shf),
        .divisor  (div_dsr),
        .busy     (div_busy),
        .quotient (quotient)
    );

    // Drive current: negated minimum of measurement and request, saturated.
    always_comb begin
        if (volt_reg == 10'd0) begin
            req = '0;
        end else if (pneg_reg) begin
            req = -$signed({1'b0, quotient[19:0]});
        end else begin
            req = $signed({1'b0, quotient[19:0]});
        end
        meas_x = {{10{meas_reg[10]}}, meas_reg};
        mn     = (meas_x < req) ? meas_x : req;
        neg    = -$signed({mn[20], mn});
        if (neg > 22'sd1023) begin
            drive_cur = CUR_MAX;
        end else if (neg < -22'sd1023) begin
            drive_cur = CUR_MIN;
        end else begin
            drive_cur = neg[10:0];
        end
    end

    assign cur_val = (op_reg == OP_CHARGE) ? meas_reg : drive_cur;
    assign cur_neg = -cur_reg;
    assign cabs    = cur_reg[10] ? cur_neg[9:0] : cur_reg[9:0];
    assign scaled  = 27'(prod_reg) * 27'(CHG_MULT);

    // Current, product and coulomb numerator with half the divisor added for rounding.
    always_ff @(posedge aclk) begin
        if (cmd.cur) begin
            cur_reg <= cur_val;
        end
        if (cmd.mul) begin
            prod_reg <= 22'(cabs) * 22'(step_reg);
        end
        if (cmd.num) begin
            num_reg <= {scaled, {SOC_SHIFT{1'b0}}} + 42'(den_reg >> 1);
        end
        if (cmd.div_soc) begin
            sat_reg <= (num_reg >= {den_reg, {DIV_QW{1'b0}}});
        end
    end

    // New SOC, clamped to the full range; a saturated quotient pins it to a bound.
    always_comb begin
        base = seeded_reg ? soc_reg : stored_reg;
        sum  = {1'b0, base} + {1'b0, quotient};
        diff = base - quotient;
        if (cur_reg[10]) begin
            if (sat_reg || (base < quotient)) begin
                soc_new = '0;
            end else if (diff > SOC_FULL) begin
                soc_new = SOC_FULL;
            end else begin
                soc_new = diff;
            end
        end else begin
            if (sat_reg || (sum > {1'b0, SOC_FULL})) begin
                soc_new = SOC_FULL;
            end else begin
                soc_new = sum[22:0];
            end
        end
    end

    // Thermal hysteresis, skipped while the contactor is open.
    always_comb begin
        fault_new = fault_reg;
        pump_new  = pump_reg;
        if (!open_reg) begin
            if (temp_reg > TEMP_CRIT) begin
                fault_new = LVL_CRIT;
            end else if (temp_reg > TEMP_HIGH) begin
                pump_new  = PUMP_FULL;
                fault_new = LVL_HIGH;
            end else if (temp_reg > TEMP_LOW) begin
                pump_new  = PUMP_HALF;
                fault_new = LVL_LOW;
            end
            if ((temp_reg < TEMP_CLEAR) && (pump_new != PUMP_OFF)) begin
                pump_new  = PUMP_OFF;
                fault_new = LVL_NONE;
            end
        end
    end

    // Status priority: contactor, critical heat, then charge or drive limit.
    always_comb begin
        cool_new = !open_reg && (fault_new != LVL_NONE);
        if (open_reg) begin
            status_new = STATUS_OPEN;
        end else if (fault_new == LVL_CRIT) begin
            status_new = STATUS_CRIT;
        end else if ((op_reg == OP_CHARGE) && ({3'b000, soc_new} >= {tgt_reg, 16'h0000})) begin
            status_new = STATUS_LIMIT;
        end else if ((op_reg != OP_CHARGE) && (soc_new <= SOC_LOW)) begin
            status_new = STATUS_LIMIT;
        end else begin
            status_new = STATUS_OK;
        end
    end

    // Step state, updated once per step when the result is committed.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            soc_reg    <= '0;
            seeded_reg <= 1'b0;
            fault_reg  <= LVL_NONE;
            pump_reg   <= PUMP_OFF;
        end else if (cmd.commit) begin
            soc_reg    <= soc_new;
            seeded_reg <= 1'b1;
            fault_reg  <= fault_new;
            pump_reg   <= pump_new;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            status_out_reg <= status_new;
            soc_out_reg    <= soc_new;
            cur_out_reg    <= (status_new == STATUS_OK) ? cur_reg : 11'sd0;
            cool_out_reg   <= cool_new;
        end
    end

    assign m_status          = status_out_reg;
    assign m_soc_estimate    = soc_out_reg;
    assign m_command_current = cur_out_reg;
    assign m_cool_request    = cool_out_reg;
    assign m_pump_duty       = pump_reg;
    assign m_thermal_level   = fault_reg;

endmodule

>>> rtl/core/battery_charge_drive_supervisor.sv
// Top level of the battery charge and drive supervisor.
`timescale 1ns / 1ps

// Each input transfer is one supervision step and yields exactly one result
// transfer. The length of a step is set mainly by the single serial divider,
// which delivers one quotient bit per clock: 20 bits for power over voltage in
// a drive operation with a non-zero pack voltage, then 23 bits for the
// coulomb-counting SOC step. A step also waits while m_ready is held low.
// One step is worked on at a time; the next input is taken once the previous
// result sits in the output register. Configuration registers are written
// through cfg_wr_en, cfg_index and cfg_wdata and must only change while idle.
// The SOC is seeded from s_stored_soc on the first step after reset.

module battery_charge_drive_supervisor
    import bcds_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_index,
    input  logic [11:0]        cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_operation,
    input  logic [9:0]         s_target,
    input  logic [9:0]         s_pack_voltage,
    input  logic signed [10:0] s_pack_current,
    input  logic               s_contactor_open,
    input  logic signed [7:0]  s_cell_temperature,
    input  logic [22:0]        s_stored_soc,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_status,
    output logic [22:0]        m_soc_estimate,
    output logic signed [10:0] m_command_current,
    output logic               m_cool_request,
    output logic [6:0]         m_pump_duty,
    output logic [1:0]         m_thermal_level
);

    cmd_t cmd;
    sts_t sts;

    bcds_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    bcds_dpath u_dpath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .sts                (sts),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_index          (cfg_index),
        .cfg_wdata          (cfg_wdata),
        .s_operation        (s_operation),
        .s_target           (s_target),
        .s_pack_voltage     (s_pack_voltage),
        .s_pack_current     (s_pack_current),
        .s_contactor_open   (s_contactor_open),
        .s_cell_temperature (s_cell_temperature),
        .s_stored_soc       (s_stored_soc),
        .m_status           (m_status),
        .m_soc_estimate     (m_soc_estimate),
        .m_command_current  (m_command_current),
        .m_cool_request     (m_cool_request),
        .m_pump_duty        (m_pump_duty),
        .m_thermal_level    (m_thermal_level)
    );

endmodule

>>> rtl/core/bcds_checker.sv
// Port-level checker for the supervisor and the bind that attaches it.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bcds_checker
    import bcds_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               cfg_wr_en,
    input logic [1:0]         cfg_index,
    input logic [11:0]        cfg_wdata,
    input logic               s_valid,
    input logic               s_ready,
    input logic [1:0]         s_operation,
    input logic [9:0]         s_target,
    input logic [9:0]         s_pack_voltage,
    input logic signed [10:0] s_pack_current,
    input logic               s_contactor_open,
    input logic signed [7:0]  s_cell_temperature,
    input logic [22:0]        s_stored_soc,
    input logic               m_valid,
    input logic               m_ready,
    input logic [1:0]         m_status,
    input logic [22:0]        m_soc_estimate,
    input logic signed [10:0] m_command_current,
    input logic               m_cool_request,
    input logic [6:0]         m_pump_duty,
    input logic [1:0]         m_thermal_level
);

    // A result waiting for transfer is not withdrawn.
    `BCDS_ASSERT(a_result_held, m_valid && !m_ready |=> m_valid, "result withdrawn before transfer")

    // No current is issued unless the step is ok.
    `BCDS_ASSERT(a_cur_gated, m_valid && (m_status != STATUS_OK) |-> (m_command_current == 11'sd0), "current issued with a fault status")

    // The pump only runs at its three duties.
    `BCDS_ASSERT_NEVER(a_pump_duty, m_valid && (m_pump_duty != PUMP_OFF) && (m_pump_duty != PUMP_HALF) && (m_pump_duty != PUMP_FULL), "pump duty outside its set")

    // With the contactor closed, cooling and critical status follow the thermal level.
    `BCDS_ASSERT(a_thermal_status, m_valid && (m_status != STATUS_OPEN) |-> (m_cool_request == (m_thermal_level != LVL_NONE)) && ((m_thermal_level == LVL_CRIT) == (m_status == STATUS_CRIT)), "status disagrees with thermal level")

endmodule

bind battery_charge_drive_supervisor bcds_checker u_bcds_checker (.*);

>>> tb/testbench.sv
// Self-checking testbench for the battery charge and drive supervisor.
`timescale 1ns / 1ps

module testbench
    import bcds_pkg::*;
;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int RANDOM_STEPS = 150;

    // One supervision step as it is presented on the input channel.
    typedef struct packed {
        logic [1:0]  op;
        logic [9:0]  target;
        logic [9:0]  voltage;
        logic [10:0] current;
        logic        open;
        logic [7:0]  temp;
        logic [22:0] stored;
    } step_t;

    // One supervision report as it leaves on the result channel.
    typedef struct packed {
        logic [1:0]  status;
        logic [22:0] soc;
        logic [10:0] current;
        logic        cool;
        logic [6:0]  pump;
        logic [1:0]  level;
    } report_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [1:0]         cfg_index = CFG_STEP_SECONDS;
    logic [11:0]        cfg_wdata = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [1:0]         s_operation = OP_CHARGE;
    logic [9:0]         s_target = '0;
    logic [9:0]         s_pack_voltage = '0;
    logic signed [10:0] s_pack_current = '0;
    logic               s_contactor_open = 1'b0;
    logic signed [7:0]  s_cell_temperature = '0;
    logic [22:0]        s_stored_soc = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [1:0]         m_status;
    logic [22:0]        m_soc_estimate;
    logic signed [10:0] m_command_current;
    logic               m_cool_request;
    logic [6:0]         m_pump_duty;
    logic [1:0]         m_thermal_level;

    // Stimulus and scoreboard storage.
    step_t   step_queue[$];
    report_t expected_reports[$];
    int      steps_outstanding = 0;
    int      mismatch_count = 0;
    int      cycle_count = 0;
    int      send_idle_pct = 18;
    int      recv_idle_pct = 75;
    int      temp_walk = 20;
    logic    in_taken = 1'b0;

    // Predicted configuration and state of the supervisor.
    longint  step_sec = 1;
    longint  cap_ah = 100;
    longint  steer_kw = 0;
    longint  soc_model = 0;
    logic    soc_seeded_model = 1'b0;
    logic [1:0] thermal_model = LVL_NONE;
    logic [6:0] pump_model = PUMP_OFF;

    battery_charge_drive_supervisor uut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_index          (cfg_index),
        .cfg_wdata          (cfg_wdata),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_operation        (s_operation),
        .s_target           (s_target),
        .s_pack_voltage     (s_pack_voltage),
        .s_pack_current     (s_pack_current),
        .s_contactor_open   (s_contactor_open),
        .s_cell_temperature (s_cell_temperature),
        .s_stored_soc       (s_stored_soc),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_status           (m_status),
        .m_soc_estimate     (m_soc_estimate),
        .m_command_current  (m_command_current),
        .m_cool_request     (m_cool_request),
        .m_pump_duty        (m_pump_duty),
        .m_thermal_level    (m_thermal_level)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // Works out the report of one step and advances the predicted state.
    function automatic report_t supervise_step(step_t it);
        report_t rep;
        longint  meas, power, req, cur, mag, num, den, q, temp, volt, target;
        meas   = $signed(it.current);
        temp   = $signed(it.temp);
        volt   = it.voltage;
        target = it.target;
        if (meas < -1023) meas = -1023;
        // Charging passes the measured current; driving limits it by power.
        if (it.op == OP_CHARGE) begin
            cur = meas;
        end else begin
            power = target;
            if (it.op != OP_FORWARD) power = power - steer_kw;
            req = 0;
            if (volt != 0) req = (power * 1000) / volt;
            cur = -((meas < req) ? meas : req);
            if (cur > 1023) cur = 1023;
            if (cur < -1023) cur = -1023;
        end
        // Coulomb counting, rounded on the magnitude, then clamped.
        if (!soc_seeded_model) begin
            soc_model = it.stored;
            soc_seeded_model = 1'b1;
        end
        mag = (cur < 0) ? -cur : cur;
        num = mag * step_sec * 819200;
        den = 441 * ((cap_ah == 0) ? 1 : cap_ah);
        q = (num + den / 2) / den;
        soc_model = (cur < 0) ? soc_model - q : soc_model + q;
        if (soc_model > longint'(SOC_FULL)) soc_model = SOC_FULL;
        if (soc_model < 0) soc_model = 0;
        rep.status = STATUS_OK;
        rep.cool = 1'b0;
        if (it.open) begin
            rep.status = STATUS_OPEN;
        end else begin
            // Thermal levels with hysteresis on the way down.
            if (temp > TEMP_CRIT) begin
                thermal_model = LVL_CRIT;
            end else if (temp > TEMP_HIGH) begin
                pump_model = PUMP_FULL;
                thermal_model = LVL_HIGH;
            end else if (temp > TEMP_LOW) begin
                pump_model = PUMP_HALF;
                thermal_model = LVL_LOW;
            end
            if (temp < TEMP_CLEAR && pump_model != PUMP_OFF) begin
                pump_model = PUMP_OFF;
                thermal_model = LVL_NONE;
            end
            rep.cool = (thermal_model != LVL_NONE);
            if (thermal_model == LVL_CRIT) rep.status = STATUS_CRIT;
            else if (it.op == OP_CHARGE && soc_model >= target * 65536)
                rep.status = STATUS_LIMIT;
            else if (it.op != OP_CHARGE && soc_model <= longint'(SOC_LOW))
                rep.status = STATUS_LIMIT;
        end
        rep.soc = 23'(soc_model);
        rep.current = (rep.status == STATUS_OK) ? 11'(cur) : 11'd0;
        rep.pump = pump_model;
        rep.level = thermal_model;
        return rep;
    endfunction

    task automatic compare_field(input string label, input longint want, input longint got);
        if (want != got) begin
            $display("%0t: %s expected %0d actual %0d", $time, label, want, got);
            mismatch_count++;
        end
    endtask

    // Sampling side: predicts on each input transfer and checks each result transfer.
    always @(posedge aclk) begin
        report_t want;
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        if (!aresetn) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= s_valid && s_ready;
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_STEP_SECONDS:    step_sec = cfg_wdata;
                    CFG_CAPACITY_AH:     cap_ah = cfg_wdata[9:0];
                    CFG_STEERING_EFFORT: steer_kw = cfg_wdata[9:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                expected_reports.push_back(supervise_step(step_t'({s_operation, s_target,
                    s_pack_voltage, s_pack_current, s_contactor_open, s_cell_temperature,
                    s_stored_soc})));
                steps_outstanding--;
            end
            if (m_valid && m_ready) begin
                if (expected_reports.size() == 0) begin
                    $display("%0t: unexpected result transfer, expected none actual status %0d",
                             $time, m_status);
                    mismatch_count++;
                end else begin
                    want = expected_reports.pop_front();
                    compare_field("status", want.status, m_status);
                    compare_field("soc_estimate", want.soc, m_soc_estimate);
                    compare_field("command_current", $signed(want.current),
                                  m_command_current);
                    compare_field("cool_request", want.cool, m_cool_request);
                    compare_field("pump_duty", want.pump, m_pump_duty);
                    compare_field("thermal_level", want.level, m_thermal_level);
                end
            end
        end
    end

    // Driving side: presents queued steps and toggles the result-side ready.
    always @(negedge aclk) begin
        step_t it;
        if (aresetn) begin
            if (!s_valid || in_taken) begin
                if (step_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    it = step_queue.pop_front();
                    s_valid            <= 1'b1;
                    s_operation        <= it.op;
                    s_target           <= it.target;
                    s_pack_voltage     <= it.voltage;
                    s_pack_current     <= it.current;
                    s_contactor_open   <= it.open;
                    s_cell_temperature <= it.temp;
                    s_stored_soc       <= it.stored;
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    task automatic push_step(input logic [1:0] op, input int target, input int volt,
                             input int cur, input logic open, input int temp);
        step_t it;
        it.op      = op;
        it.target  = 10'(target);
        it.voltage = 10'(volt);
        it.current = 11'(cur);
        it.open    = open;
        it.temp    = 8'(temp);
        it.stored  = 23'($urandom_range(0, 6553600));
        step_queue.push_back(it);
        steps_outstanding++;
    endtask

    task automatic wait_idle();
        while (steps_outstanding != 0 || expected_reports.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_register(input logic [1:0] idx, input int data);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= 12'(data);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic configure(input int secs, input int cap, input int steer);
        write_register(CFG_STEP_SECONDS, secs);
        write_register(CFG_CAPACITY_AH, cap);
        write_register(CFG_STEERING_EFFORT, steer);
    endtask

    // Random steps: mostly closed contactor with a wandering temperature.
    task automatic queue_random_steps(input int count);
        logic [1:0] op;
        int target, volt, cur;
        for (int i = 0; i < count; i++) begin
            op = 2'($urandom_range(0, 3));
            if ($urandom_range(0, 19) == 0) temp_walk = int'($urandom_range(0, 167)) - 40;
            else temp_walk = temp_walk + int'($urandom_range(0, 12)) - 6;
            if (temp_walk < -40) temp_walk = -40;
            if (temp_walk > 127) temp_walk = 127;
            if (op == OP_CHARGE && $urandom_range(0, 9) != 0) target = $urandom_range(0, 100);
            else target = $urandom_range(0, 1023);
            case ($urandom_range(0, 9))
                0: volt = 0;
                1: volt = $urandom_range(1, 15);
                default: volt = $urandom_range(0, 1023);
            endcase
            if ($urandom_range(0, 9) == 0) cur = $urandom_range(0, 1) ? 1023 : -1023;
            else cur = int'($urandom_range(0, 2046)) - 1023;
            push_step(op, target, volt, cur, $urandom_range(0, 99) < 8, temp_walk);
        end
        wait_idle();
    endtask

    initial begin
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed steps at the reset settings: seeding, thermal walk, contactor.
        push_step(OP_CHARGE, 50, 400, 100, 1'b0, 25);
        push_step(OP_CHARGE, 0, 0, -1024, 1'b0, -40);
        push_step(OP_FORWARD, 1023, 1023, 1023, 1'b0, 36);
        push_step(OP_LEFT, 10, 0, -1023, 1'b0, 46);
        push_step(OP_RIGHT, 0, 1, 500, 1'b0, 56);
        push_step(OP_CHARGE, 100, 300, 1023, 1'b1, 20);
        push_step(OP_FORWARD, 5, 1023, -500, 1'b0, 40);
        push_step(OP_FORWARD, 5, 500, 200, 1'b0, 30);
        push_step(OP_FORWARD, 5, 500, 200, 1'b0, 28);
        push_step(OP_CHARGE, 1023, 250, 50, 1'b0, 27);
        push_step(OP_CHARGE, 100, 250, 1023, 1'b0, 127);
        push_step(OP_CHARGE, 100, 250, 1023, 1'b0, -1);
        push_step(OP_CHARGE, 100, 250, 1023, 1'b0, 50);
        push_step(OP_CHARGE, 100, 250, 1023, 1'b0, 10);
        wait_idle();

        // An hour-long step, zero capacity and full steering effort.
        configure(3600, 0, 1023);
        push_step(OP_CHARGE, 100, 400, 1023, 1'b0, 20);
        push_step(OP_LEFT, 1023, 400, 1023, 1'b0, 20);
        push_step(OP_RIGHT, 0, 1, -1023, 1'b0, 20);
        push_step(OP_FORWARD, 1023, 1, 1023, 1'b0, 20);
        push_step(OP_FORWARD, 100, 500, 1000, 1'b0, 20);
        push_step(OP_CHARGE, 1, 100, 2, 1'b0, 20);
        push_step(OP_LEFT, 1023, 1023, 0, 1'b0, 20);
        wait_idle();

        // Random phases, the sender mostly busy and the receiver mostly stalled.
        configure(60, 50, 30);
        queue_random_steps(RANDOM_STEPS);
        configure(3600, 1, 1023);
        queue_random_steps(RANDOM_STEPS);

        // The other way round.
        send_idle_pct = 75;
        recv_idle_pct = 18;
        configure(1, 1023, 0);
        queue_random_steps(RANDOM_STEPS);
        configure($urandom_range(1, 3600), $urandom_range(1, 1023), $urandom_range(0, 1023));
        queue_random_steps(RANDOM_STEPS);

        // Back-to-back transfers on both sides.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        configure(3600, 1023, 512);
        queue_random_steps(RANDOM_STEPS);
        configure(10, 1, 1023);
        queue_random_steps(RANDOM_STEPS);

        repeat (60) @(negedge aclk);
        if (mismatch_count == 0 && expected_reports.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
